// ===== rtl/mdc_pkg.sv =====
// Shared codes, types and default sizes for the maze carver.
package mdc_pkg;

    // Default grid size
    localparam int DEF_COLUMNS = 12;
    localparam int DEF_ROWS    = 6;

    // Fixed field widths
    localparam int RND_W  = 16;
    localparam int CELL_W = 7;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_CARVE = 2'd1,
        ACT_BACK  = 2'd2,
        ACT_DONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        DIR_TOP    = 2'd0,
        DIR_RIGHT  = 2'd1,
        DIR_BOTTOM = 2'd2,
        DIR_LEFT   = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_EVAL
    } t_state;

    // Neighbour choice handed from the picker to the sequencer
    typedef struct packed {
        logic found;
        t_dir dir;
    } t_pick;

endpackage

// ===== rtl/mdc_visit_mem.sv =====
// Visited map: one word per grid row, two registered read ports, one write port.
module mdc_visit_mem import mdc_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int RW     = $clog2(ROWS)
) (
    input  logic               i_clk,
    input  logic               i_rd_en_a,
    input  logic [RW-1:0]      i_rd_addr_a,
    output logic [COLUMNS-1:0] o_rd_data_a,
    input  logic               i_rd_en_b,
    input  logic [RW-1:0]      i_rd_addr_b,
    output logic [COLUMNS-1:0] o_rd_data_b,
    input  logic               i_wr_en,
    input  logic [RW-1:0]      i_wr_addr,
    input  logic [COLUMNS-1:0] i_wr_data
);

    logic [COLUMNS-1:0] r_mem [ROWS];
    logic [COLUMNS-1:0] r_rd_data_a;
    logic [COLUMNS-1:0] r_rd_data_b;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read two rows; data holds while a port is idle
    always_ff @(posedge i_clk) begin
        if (i_rd_en_a) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
        end
        if (i_rd_en_b) begin
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

// ===== rtl/mdc_stack_mem.sv =====
// Walk stack storage: one write port and one registered read port.
module mdc_stack_mem import mdc_pkg::*; #(
    parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
    parameter int WIDTH = $clog2(DEF_COLUMNS) + $clog2(DEF_ROWS),
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Push entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Fetch top of stack; data holds while idle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/mdc_pick.sv =====
// Neighbour picker: gathers unvisited neighbours and selects one by random mod count.
module mdc_pick import mdc_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int CLW    = $clog2(COLUMNS),
    localparam int RW     = $clog2(ROWS)
) (
    input  logic [CLW-1:0]     i_col,
    input  logic [RW-1:0]      i_row,
    input  logic [COLUMNS-1:0] i_up_row,
    input  logic [COLUMNS-1:0] i_mid_row,
    input  logic [COLUMNS-1:0] i_down_row,
    input  logic [RND_W-1:0]   i_random_word,
    output t_pick              o_pick
);

    // Remainder by three: base-4 digits sum to the same residue
    function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] f;
        logic [1:0] r;
        s = '0;
        for (int k = 0; k < RND_W / 2; k++) begin
            s = s + 5'(v[2*k +: 2]);
        end
        f = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        case (f) inside
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    logic [3:0]         w_open;
    logic [COLUMNS-1:0] w_mid_sh;
    logic [2:0]         w_count;
    logic [1:0]         w_sel;

    // Flag neighbours inside the grid and not yet visited
    assign w_mid_sh = i_mid_row >> i_col;

    always_comb begin
        w_open[DIR_TOP]    = (i_row != '0) && !i_up_row[i_col];
        w_open[DIR_RIGHT]  = (i_col != CLW'(COLUMNS - 1)) && !w_mid_sh[1];
        w_open[DIR_BOTTOM] = (i_row != RW'(ROWS - 1)) && !i_down_row[i_col];
        w_open[DIR_LEFT]   = (i_col != '0) && !i_mid_row[i_col - 1'b1];
    end

    assign w_count = 3'(w_open[0]) + 3'(w_open[1]) + 3'(w_open[2]) + 3'(w_open[3]);

    // Reduce the random word by the candidate count
    always_comb begin
        case (w_count)
            3'd2:    w_sel = {1'b0, i_random_word[0]};
            3'd3:    w_sel = mod3(i_random_word);
            3'd4:    w_sel = i_random_word[1:0];
            default: w_sel = 2'd0;
        endcase
    end

    // Take the selected open neighbour in top, right, bottom, left order
    always_comb begin
        logic [2:0] v_seen;
        v_seen       = '0;
        o_pick.found = 1'b0;
        o_pick.dir   = DIR_TOP;
        for (int k = 0; k < 4; k++) begin
            if (w_open[k]) begin
                if (!o_pick.found && (v_seen == {1'b0, w_sel})) begin
                    o_pick.found = 1'b1;
                    o_pick.dir   = t_dir'(2'(k));
                end
                v_seen = v_seen + 3'd1;
            end
        end
    end

endmodule

// ===== rtl/maze_dfs_carver_top.sv =====
// Top level of the depth-first maze carver: sequencer, position, stack depth, result register.
//
// Carves a COLUMNS by ROWS maze by a randomized depth-first walk; cell index is
// column plus row times COLUMNS. The visited map is kept as one word per grid
// row in a memory with two read ports: a walk step item reads the rows above
// and below on acceptance, the current row in the read state, and then
// evaluates and writes in the evaluate state. A start item clears the visited
// map one row per cycle; after reset the same clearing pass runs before the
// first item is taken. The result register lets a new item in while the last
// result waits; a result that is still not taken holds the block at the end of
// the next item.
module maze_dfs_carver_top import mdc_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic [RND_W-1:0]   i_random_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_action,
    output logic [CELL_W-1:0]  o_from_cell,
    output logic [CELL_W-1:0]  o_to_cell,
    output logic [1:0]         o_carve_direction
);

    localparam int NCELLS = COLUMNS * ROWS;
    localparam int CLW    = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(NCELLS);
    localparam int DW     = $clog2(NCELLS + 1);
    localparam int SW     = $clog2(NCELLS);
    localparam int PW     = CLW + RW;

    // Cell index from row and column
    function automatic logic [CELL_W-1:0] cell_of(input logic [RW-1:0] row,
                                                  input logic [CLW-1:0] col);
        logic [CW-1:0] c;
        c = CW'(row) * CW'(COLUMNS) + CW'(col);
        return CELL_W'(c);
    endfunction

    t_state              r_state, n_state;
    logic [CLW-1:0]      r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [DW-1:0]       r_depth, n_depth;
    logic [RW-1:0]       r_clr, n_clr;
    logic [RND_W-1:0]    r_rnd;
    logic [COLUMNS-1:0]  r_up_row;
    logic                r_out_valid, n_out_valid;
    t_action             r_action, n_action;
    logic [CELL_W-1:0]   r_from, n_from;
    logic [CELL_W-1:0]   r_to, n_to;
    t_dir                r_dir, n_dir;

    logic                w_in_acc;
    logic                w_out_free;

    logic                vm_rd_en_a, vm_rd_en_b, vm_wr_en;
    logic [RW-1:0]       vm_rd_addr_a, vm_rd_addr_b, vm_wr_addr;
    logic [COLUMNS-1:0]  vm_rd_data_a, vm_rd_data_b, vm_wr_data;

    logic                sk_rd_en, sk_wr_en;
    logic [SW-1:0]       sk_rd_addr, sk_wr_addr;
    logic [PW-1:0]       sk_rd_data, sk_wr_data;

    t_pick               w_pick;
    logic [CLW-1:0]      w_next_col;
    logic [RW-1:0]       w_next_row;
    logic [COLUMNS-1:0]  w_next_word;

    mdc_visit_mem #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_visit_mem (
        .i_clk       (i_clk),
        .i_rd_en_a   (vm_rd_en_a),
        .i_rd_addr_a (vm_rd_addr_a),
        .o_rd_data_a (vm_rd_data_a),
        .i_rd_en_b   (vm_rd_en_b),
        .i_rd_addr_b (vm_rd_addr_b),
        .o_rd_data_b (vm_rd_data_b),
        .i_wr_en     (vm_wr_en),
        .i_wr_addr   (vm_wr_addr),
        .i_wr_data   (vm_wr_data)
    );

    mdc_stack_mem #(
        .DEPTH (NCELLS),
        .WIDTH (PW)
    ) u_stack_mem (
        .i_clk     (i_clk),
        .i_rd_en   (sk_rd_en),
        .i_rd_addr (sk_rd_addr),
        .o_rd_data (sk_rd_data),
        .i_wr_en   (sk_wr_en),
        .i_wr_addr (sk_wr_addr),
        .i_wr_data (sk_wr_data)
    );

    mdc_pick #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_pick (
        .i_col         (r_col),
        .i_row         (r_row),
        .i_up_row      (r_up_row),
        .i_mid_row     (vm_rd_data_a),
        .i_down_row    (vm_rd_data_b),
        .i_random_word (r_rnd),
        .o_pick        (w_pick)
    );

    // Handshake
    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // Target cell and the row word it lives in
    always_comb begin
        w_next_col  = r_col;
        w_next_row  = r_row;
        w_next_word = vm_rd_data_a;
        case (w_pick.dir)
            DIR_TOP: begin
                w_next_row  = r_row - 1'b1;
                w_next_word = r_up_row;
            end
            DIR_RIGHT: begin
                w_next_col = r_col + 1'b1;
            end
            DIR_BOTTOM: begin
                w_next_row  = r_row + 1'b1;
                w_next_word = vm_rd_data_b;
            end
            default: begin
                w_next_col = r_col - 1'b1;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == RW'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_cmd == CMD_START) ? ST_START : ST_READ;
                end
            end
            ST_START: begin
                if (w_out_free) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory control, walk update and result
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_depth     = r_depth;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_out_stall;
        n_action    = r_action;
        n_from      = r_from;
        n_to        = r_to;
        n_dir       = r_dir;

        vm_rd_en_a   = 1'b0;
        vm_rd_addr_a = '0;
        vm_rd_en_b   = 1'b0;
        vm_rd_addr_b = '0;
        vm_wr_en     = 1'b0;
        vm_wr_addr   = '0;
        vm_wr_data   = '0;
        sk_rd_en     = 1'b0;
        sk_rd_addr   = '0;
        sk_wr_en     = 1'b0;
        sk_wr_addr   = '0;
        sk_wr_data   = '0;

        unique case (r_state)
            ST_CLEAR: begin
                // Sweep rows; cell 0 starts visited
                vm_wr_en   = 1'b1;
                vm_wr_addr = r_clr;
                vm_wr_data = (r_clr == '0) ? COLUMNS'(1) : '0;
                n_clr      = (r_clr == RW'(ROWS - 1)) ? '0 : r_clr + 1'b1;
            end
            ST_IDLE: begin
                // Fetch rows above and below, and the stack top
                if (w_in_acc && (i_cmd == CMD_STEP)) begin
                    vm_rd_en_a   = 1'b1;
                    vm_rd_addr_a = (r_row == '0) ? r_row : r_row - 1'b1;
                    vm_rd_en_b   = 1'b1;
                    vm_rd_addr_b = (r_row == RW'(ROWS - 1)) ? r_row : r_row + 1'b1;
                    sk_rd_en     = 1'b1;
                    sk_rd_addr   = (r_depth == '0) ? '0 : SW'(r_depth - 1'b1);
                end
            end
            ST_START: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_action    = ACT_START;
                    n_from      = cell_of(r_row, r_col);
                    n_to        = '0;
                    n_dir       = DIR_TOP;
                    n_col       = '0;
                    n_row       = '0;
                    n_depth     = '0;
                    n_clr       = '0;
                end
            end
            ST_READ: begin
                // Fetch the current row
                vm_rd_en_a   = 1'b1;
                vm_rd_addr_a = r_row;
            end
            ST_EVAL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_from      = cell_of(r_row, r_col);
                    n_dir       = DIR_TOP;
                    if (w_pick.found) begin
                        // Carve: mark target, push current cell, advance
                        n_action   = ACT_CARVE;
                        n_dir      = w_pick.dir;
                        n_col      = w_next_col;
                        n_row      = w_next_row;
                        n_to       = cell_of(w_next_row, w_next_col);
                        vm_wr_en   = 1'b1;
                        vm_wr_addr = w_next_row;
                        vm_wr_data = w_next_word | (COLUMNS'(1) << w_next_col);
                        if (r_depth < DW'(NCELLS)) begin
                            sk_wr_en   = 1'b1;
                            sk_wr_addr = r_depth[SW-1:0];
                            sk_wr_data = {r_row, r_col};
                            n_depth    = r_depth + 1'b1;
                        end
                    end else if (r_depth != '0) begin
                        // Backtrack: pop
                        n_action = ACT_BACK;
                        n_row    = sk_rd_data[PW-1:CLW];
                        n_col    = sk_rd_data[CLW-1:0];
                        n_to     = cell_of(sk_rd_data[PW-1:CLW], sk_rd_data[CLW-1:0]);
                        n_depth  = r_depth - 1'b1;
                    end else begin
                        n_action = ACT_DONE;
                        n_to     = cell_of(r_row, r_col);
                    end
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_from   <= n_from;
        r_to     <= n_to;
        r_dir    <= n_dir;
        if (w_in_acc) begin
            r_rnd <= i_random_word;
        end
        if (r_state == ST_READ) begin
            r_up_row <= vm_rd_data_a;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_action          = r_action;
    assign o_from_cell       = r_from;
    assign o_to_cell         = r_to;
    assign o_carve_direction = r_dir;

endmodule

// ===== tb/maze_walk_checker.sv =====
`timescale 1ns / 1ps
// Walk predictor and result comparator for the maze carver, fed from both channels.
module maze_walk_checker import mdc_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_cmd,
    input  logic [RND_W-1:0]  i_random_word,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [1:0]        i_action,
    input  logic [CELL_W-1:0] i_from_cell,
    input  logic [CELL_W-1:0] i_to_cell,
    input  logic [1:0]        i_carve_direction,
    output int                o_mismatches,
    output int                o_pending
);

    localparam int NCELLS = COLUMNS * ROWS;

    typedef struct packed {
        t_action           action;
        logic [CELL_W-1:0] from_cell;
        logic [CELL_W-1:0] to_cell;
        t_dir              carve_direction;
    } t_move;

    logic              visited [NCELLS];
    logic [CELL_W-1:0] trail [NCELLS];
    int                trail_depth;
    logic [CELL_W-1:0] position;
    t_move             expected_moves [$];

    // Clear the map and go back to the top left cell
    task automatic restart_walk();
        foreach (visited[k]) visited[k] = 1'b0;
        visited[0] = 1'b1;
        trail_depth = 0;
        position = '0;
    endtask

    // Advance the walk by one item and queue the move it must report
    task automatic carve_step(input logic cmd, input logic [RND_W-1:0] word);
        t_move move;
        int    here;
        int    col;
        int    row;
        int    count;
        int    pick;
        int    back;
        int    cand_cell [4];
        t_dir  cand_dir [4];
        here = int'(position);
        if (cmd == CMD_START) begin
            restart_walk();
            move = '{ACT_START, CELL_W'(here), CELL_W'(0), DIR_TOP};
        end else begin
            if (here >= NCELLS) here = 0;
            col = here % COLUMNS;
            row = here / COLUMNS;
            count = 0;
            // Gather unvisited neighbours: top, right, bottom, left
            if (row > 0 && !visited[here - COLUMNS]) begin
                cand_cell[count] = here - COLUMNS;
                cand_dir[count] = DIR_TOP;
                count++;
            end
            if (col + 1 < COLUMNS && !visited[here + 1]) begin
                cand_cell[count] = here + 1;
                cand_dir[count] = DIR_RIGHT;
                count++;
            end
            if (row + 1 < ROWS && !visited[here + COLUMNS]) begin
                cand_cell[count] = here + COLUMNS;
                cand_dir[count] = DIR_BOTTOM;
                count++;
            end
            if (col > 0 && !visited[here - 1]) begin
                cand_cell[count] = here - 1;
                cand_dir[count] = DIR_LEFT;
                count++;
            end
            if (count > 0) begin
                pick = int'(word) % count;
                visited[cand_cell[pick]] = 1'b1;
                // Drop the push if the trail is already full
                if (trail_depth < NCELLS) begin
                    trail[trail_depth] = CELL_W'(here);
                    trail_depth++;
                end
                position = CELL_W'(cand_cell[pick]);
                move = '{ACT_CARVE, CELL_W'(here), CELL_W'(cand_cell[pick]), cand_dir[pick]};
            end else if (trail_depth > 0) begin
                trail_depth--;
                back = int'(trail[trail_depth]);
                if (back >= NCELLS) back = 0;
                position = CELL_W'(back);
                move = '{ACT_BACK, CELL_W'(here), CELL_W'(back), DIR_TOP};
            end else begin
                move = '{ACT_DONE, CELL_W'(here), CELL_W'(here), DIR_TOP};
            end
        end
        // Append to the tail of the expected queue
        expected_moves = {expected_moves, move};
    endtask

    // Compare the result item first, then record the input item
    always @(posedge i_clk) begin
        t_move oldest;
        if (!i_rst_n) begin
            foreach (trail[k]) trail[k] = '0;
            restart_walk();
            expected_moves.delete();
            o_mismatches = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_moves.size() == 0) begin
                    $error("unexpected result item: action %0d from %0d to %0d direction %0d",
                           i_action, i_from_cell, i_to_cell, i_carve_direction);
                    o_mismatches++;
                end else begin
                    oldest = expected_moves.pop_front();
                    if (i_action !== oldest.action) begin
                        $error("action: expected %0d, got %0d", oldest.action, i_action);
                        o_mismatches++;
                    end
                    if (i_from_cell !== oldest.from_cell) begin
                        $error("from_cell: expected %0d, got %0d", oldest.from_cell, i_from_cell);
                        o_mismatches++;
                    end
                    if (i_to_cell !== oldest.to_cell) begin
                        $error("to_cell: expected %0d, got %0d", oldest.to_cell, i_to_cell);
                        o_mismatches++;
                    end
                    if (i_carve_direction !== oldest.carve_direction) begin
                        $error("carve_direction: expected %0d, got %0d",
                               oldest.carve_direction, i_carve_direction);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                carve_step(i_cmd, i_random_word);
            end
        end
        o_pending = expected_moves.size();
    end

endmodule

// ===== tb/maze_dfs_carver_top_test.sv =====
`timescale 1ns / 1ps
// Stimulus, handshake pacing and verdict for the maze carver regression.
module maze_dfs_carver_top_test;
    import mdc_pkg::*;

    localparam int COLUMNS       = DEF_COLUMNS;
    localparam int ROWS          = DEF_ROWS;
    localparam int NCELLS        = COLUMNS * ROWS;
    localparam int RANDOM_ITEMS  = 850;
    localparam int SETTLE_CYCLES = 4 * (ROWS + 2);

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_cmd         = CMD_START;
    logic [RND_W-1:0]  in_random_word = '0;
    logic              out_stall      = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [1:0]        action;
    logic [CELL_W-1:0] from_cell;
    logic [CELL_W-1:0] to_cell;
    logic [1:0]        carve_direction;
    int                mismatches;
    int                pending;
    int                items_sent     = 0;
    bit                tx_gaps_on     = 1'b1;
    bit                rx_stalls_on   = 1'b1;

    always #1 clk = ~clk;

    maze_dfs_carver_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_cmd             (in_cmd),
        .i_random_word     (in_random_word),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_action          (action),
        .o_from_cell       (from_cell),
        .o_to_cell         (to_cell),
        .o_carve_direction (carve_direction)
    );

    maze_walk_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) walk_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_cmd             (in_cmd),
        .i_random_word     (in_random_word),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_action          (action),
        .i_from_cell       (from_cell),
        .i_to_cell         (to_cell),
        .i_carve_direction (carve_direction),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    // Mostly uniform words, with the extremes and tiny values mixed in
    function automatic logic [RND_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return RND_W'($urandom_range(0, 7));
            default: return RND_W'($urandom);
        endcase
    endfunction

    // Idle a random gap, then hold the item until it is taken
    task automatic send_item(input logic cmd, input logic [RND_W-1:0] word);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_gaps_on = !tx_gaps_on;
        gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_cmd <= cmd;
        in_random_word <= word;
        do @(posedge clk); while (!(in_valid && !in_stall));
        items_sent++;
    endtask

    // Stop sending until every open item has produced its result
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Result side: stall a random number of cycles before each item
    initial begin : result_sink
        int hold;
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_stalls_on = !rx_stalls_on;
            hold = rx_stalls_on ? $urandom_range(0, 9) : 0;
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    initial begin : stimulus
        int steps;
        int burst;
        int item_goal;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Walk straight out of reset with extreme and small words
        send_item(CMD_STEP, 16'h0000);
        send_item(CMD_STEP, 16'hFFFF);
        send_item(CMD_STEP, 16'h0001);
        send_item(CMD_STEP, 16'h0002);
        send_item(CMD_STEP, 16'h0003);
        // Restart away from the origin, then restart while at the origin
        send_item(CMD_START, 16'hFFFF);
        send_item(CMD_START, 16'h0000);
        // Steer into a dead end at cell 12: 0, 1, 13, 25, 24, 12
        send_item(CMD_STEP, 16'h0000);
        send_item(CMD_STEP, 16'h0001);
        send_item(CMD_STEP, 16'h0001);
        send_item(CMD_STEP, 16'h0002);
        send_item(CMD_STEP, 16'h0000);
        // Backtrack out of the dead end, then carve on
        send_item(CMD_STEP, 16'hFFFF);
        send_item(CMD_STEP, 16'h8000);
        send_item(CMD_STEP, 16'h5555);
        send_item(CMD_STEP, 16'hAAAA);
        send_item(CMD_STEP, 16'h7FFF);
        send_item(CMD_STEP, 16'hFFFE);
        drain_results();

        // Mostly whole mazes run past the finish, some aborted walks and noise
        item_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < item_goal) begin
            if ($urandom_range(0, 2) == 0) drain_results();
            if ($urandom_range(0, 3) != 0) begin
                send_item(CMD_START, pick_word());
                steps = 2 * NCELLS - 1 + $urandom_range(0, 8);
                // Trim the walk so the item count lands on the goal
                if (steps > item_goal - items_sent) steps = item_goal - items_sent;
                repeat (steps) send_item(CMD_STEP, pick_word());
            end else begin
                burst = $urandom_range(1, 40);
                if (burst > item_goal - items_sent) burst = item_goal - items_sent;
                repeat (burst) begin
                    send_item(($urandom_range(0, 5) == 0) ? CMD_START : CMD_STEP, pick_word());
                end
            end
        end

        // Let the last results land, then give the verdict
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (pending != 0) $error("%0d result items never arrived", pending);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake
    initial begin : watchdog
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mdc_pkg.sv
rtl/mdc_visit_mem.sv
rtl/mdc_stack_mem.sv
rtl/mdc_pick.sv
rtl/maze_dfs_carver_top.sv
tb/maze_walk_checker.sv
tb/maze_dfs_carver_top_test.sv
